FILE: rtl/core/qcvn_pkg.sv
// Shared widths and constants for the quad cell vertex normal pipeline.
// No dependencies; every other file of the block imports this package.
package qcvn_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int FACE_W          = 34;
    localparam int SUM_W           = FACE_W + 1;
    localparam int NORM_TOP        = 23;
    localparam int MAG_W           = NORM_TOP + 1;
    localparam int SQ_W            = 2 * MAG_W + 2;
    localparam int ROOT_W          = SQ_W / 2;
    localparam int REM_W           = ROOT_W + 3;
    localparam int TOP_W           = 6;
    localparam int QUO_W           = 15;
    localparam int SHARED_W        = 16;
    localparam int SHARED_ONE      = 16384;
    localparam int NUM_W           = MAG_W + QUO_W + 1;
    localparam int DEN_W           = ROOT_W + 1;

    localparam int FACE_STAGES = 3;
    localparam int PREP_STAGES = 6;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int DIV_STAGES  = QUO_W;
    localparam int TOTAL_STAGES = FACE_STAGES + PREP_STAGES + SQRT_STAGES + DIV_STAGES;

    typedef logic signed [FACE_W-1:0] face_t;
    typedef logic [MAG_W-1:0]         mag_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } sign_info_t;

endpackage

FILE: rtl/core/qcvn_face.sv
// Three-stage face normal unit: edge differences, products, cross terms.
// Depends on qcvn_pkg.
module qcvn_face #(
    parameter int CW = 16
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [CW-1:0]   ul [3],
    input  logic signed [CW-1:0]   ur [3],
    input  logic signed [CW-1:0]   ll [3],
    input  logic signed [CW-1:0]   lr [3],
    output qcvn_pkg::face_t        f1 [3],
    output qcvn_pkg::face_t        f2 [3]
);
    import qcvn_pkg::*;

    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int XW = (PW + 1 > FACE_W) ? PW + 1 : FACE_W;

    logic signed [DW-1:0] u1_reg [3];
    logic signed [DW-1:0] v1_reg [3];
    logic signed [DW-1:0] u2_reg [3];
    logic signed [DW-1:0] v2_reg [3];
    logic signed [PW-1:0] pa1_reg [3];
    logic signed [PW-1:0] pb1_reg [3];
    logic signed [PW-1:0] pa2_reg [3];
    logic signed [PW-1:0] pb2_reg [3];
    face_t                f1_reg [3];
    face_t                f2_reg [3];

    genvar c;
    generate
        for (c = 0; c < 3; c++) begin : g_comp
            localparam int C1 = (c + 1) % 3;
            localparam int C2 = (c + 2) % 3;
            logic signed [XW-1:0] x1;
            logic signed [XW-1:0] x2;

            assign x1 = XW'(pa1_reg[c]) - XW'(pb1_reg[c]);
            assign x2 = XW'(pa2_reg[c]) - XW'(pb2_reg[c]);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    u1_reg[c]  <= DW'(ur[c]) - DW'(ul[c]);
                    v1_reg[c]  <= DW'(ll[c]) - DW'(ul[c]);
                    u2_reg[c]  <= DW'(ur[c]) - DW'(ll[c]);
                    v2_reg[c]  <= DW'(lr[c]) - DW'(ll[c]);
                    pa1_reg[c] <= PW'(u1_reg[C1]) * PW'(v1_reg[C2]);
                    pb1_reg[c] <= PW'(u1_reg[C2]) * PW'(v1_reg[C1]);
                    pa2_reg[c] <= PW'(u2_reg[C1]) * PW'(v2_reg[C2]);
                    pb2_reg[c] <= PW'(u2_reg[C2]) * PW'(v2_reg[C1]);
                    // wrap to the face width
                    f1_reg[c]  <= x1[FACE_W-1:0];
                    f2_reg[c]  <= x2[FACE_W-1:0];
                end
            end

            assign f1[c] = f1_reg[c];
            assign f2[c] = f2_reg[c];
        end
    endgenerate

endmodule

FILE: rtl/core/qcvn_prep.sv
// Six-stage normalize front end: sum, magnitude, max, leading one, shift,
// squares and their sum. Depends on qcvn_pkg.
module qcvn_prep (
    input  logic                         clk,
    input  logic                         en,
    input  qcvn_pkg::face_t              f1 [3],
    input  qcvn_pkg::face_t              f2 [3],
    output qcvn_pkg::mag_t               mag [3],
    output qcvn_pkg::sign_info_t         info,
    output logic [qcvn_pkg::SQ_W-1:0]    sq_sum
);
    import qcvn_pkg::*;

    localparam int WIDE_W = SUM_W + NORM_TOP;

    logic [SUM_W-1:0]      m1_reg [3];
    logic [SUM_W-1:0]      m2_reg [3];
    logic [SUM_W-1:0]      m3_reg [3];
    logic [SUM_W-1:0]      mx_reg;
    logic [TOP_W-1:0]      top_reg;
    mag_t                  m4_reg [3];
    mag_t                  m5_reg [3];
    mag_t                  m6_reg [3];
    logic [2*MAG_W-1:0]    sq5_reg [3];
    logic [SQ_W-1:0]       sq6_reg;
    sign_info_t            i1_reg;
    sign_info_t            i2_reg;
    sign_info_t            i3_reg;
    sign_info_t            i4_reg;
    sign_info_t            i5_reg;
    sign_info_t            i6_reg;

    logic signed [SUM_W-1:0] s [3];
    logic [2:0]              neg;
    logic [SUM_W-1:0]        mx_next;
    logic [TOP_W-1:0]        top_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s[i]   = SUM_W'(f1[i]) + SUM_W'(f2[i]);
            neg[i] = s[i][SUM_W-1];
        end
    end

    always_comb
    begin
        mx_next = m1_reg[0];
        if (m1_reg[1] > mx_next)
            mx_next = m1_reg[1];
        if (m1_reg[2] > mx_next)
            mx_next = m1_reg[2];
    end

    // highest set bit wins
    always_comb
    begin
        top_next = '0;
        for (int b = 0; b < SUM_W; b++)
        begin
            if (mx_reg[b])
                top_next = TOP_W'(b);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m1_reg[i]  <= neg[i] ? SUM_W'(-s[i]) : SUM_W'(s[i]);
                m2_reg[i]  <= m1_reg[i];
                m3_reg[i]  <= m2_reg[i];
                m4_reg[i]  <= MAG_W'(({m3_reg[i], NORM_TOP'(0)}) >> top_reg);
                m5_reg[i]  <= m4_reg[i];
                m6_reg[i]  <= m5_reg[i];
                sq5_reg[i] <= (2*MAG_W)'(m4_reg[i]) * (2*MAG_W)'(m4_reg[i]);
            end
            i1_reg.neg   <= neg;
            i1_reg.degen <= 1'b0;
            i2_reg.neg   <= i1_reg.neg;
            i2_reg.degen <= (mx_next == '0);
            mx_reg       <= mx_next;
            i3_reg       <= i2_reg;
            top_reg      <= top_next;
            i4_reg       <= i3_reg;
            i5_reg       <= i4_reg;
            i6_reg       <= i5_reg;
            sq6_reg      <= SQ_W'(sq5_reg[0]) + SQ_W'(sq5_reg[1]) + SQ_W'(sq5_reg[2]);
        end
    end

    assign mag[0] = m6_reg[0];
    assign mag[1] = m6_reg[1];
    assign mag[2] = m6_reg[2];
    assign info   = i6_reg;
    assign sq_sum = sq6_reg;

endmodule

FILE: rtl/core/qcvn_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on qcvn_pkg.
module qcvn_sqrt (
    input  logic                        clk,
    input  logic                        en,
    input  logic [qcvn_pkg::SQ_W-1:0]   rad,
    output logic [qcvn_pkg::ROOT_W-1:0] root
);
    import qcvn_pkg::*;

    logic [SQ_W-1:0]   rad_reg  [SQRT_STAGES];
    logic [REM_W-1:0]  rem_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0] root_reg [SQRT_STAGES];

    genvar s;
    generate
        for (s = 0; s < SQRT_STAGES; s++) begin : g_stage
            logic [SQ_W-1:0]   rad_in;
            logic [REM_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [REM_W-1:0]  rem_sh;
            logic [REM_W-1:0]  trial;

            if (s == 0) begin : g_first
                assign rad_in  = rad;
                assign rem_in  = '0;
                assign root_in = '0;
            end else begin : g_next
                assign rad_in  = rad_reg[s-1];
                assign rem_in  = rem_reg[s-1];
                assign root_in = root_reg[s-1];
            end

            assign rem_sh = {rem_in[REM_W-3:0], rad_in[SQ_W-1:SQ_W-2]};
            assign trial  = REM_W'({root_in, 2'b01});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[s] <= {rad_in[SQ_W-3:0], 2'b00};
                    if (rem_sh >= trial)
                    begin
                        rem_reg[s]  <= rem_sh - trial;
                        root_reg[s] <= {root_in[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[s]  <= rem_sh;
                        root_reg[s] <= {root_in[ROOT_W-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign root = root_reg[SQRT_STAGES-1];

endmodule

FILE: rtl/core/qcvn_div.sv
// Three-lane pipelined restoring divider: q = (32768*m + L) / (2*L),
// one quotient bit per stage. Depends on qcvn_pkg.
module qcvn_div (
    input  logic                        clk,
    input  logic                        en,
    input  qcvn_pkg::mag_t              mag [3],
    input  logic [qcvn_pkg::ROOT_W-1:0] len,
    output logic [qcvn_pkg::QUO_W-1:0]  quo [3]
);
    import qcvn_pkg::*;

    logic [DEN_W-1:0] den_reg [DIV_STAGES];
    logic [NUM_W-1:0] rem_reg [DIV_STAGES][3];
    logic [QUO_W-1:0] q_reg   [DIV_STAGES][3];

    genvar s, l;
    generate
        for (s = 0; s < DIV_STAGES; s++) begin : g_stage
            localparam int K = DIV_STAGES - 1 - s;
            logic [DEN_W-1:0] den_in;
            logic [NUM_W-1:0] dsh;

            if (s == 0) begin : g_first
                assign den_in = {len, 1'b0};
            end else begin : g_next
                assign den_in = den_reg[s-1];
            end

            assign dsh = NUM_W'(den_in) << K;

            always_ff @(posedge clk)
            begin
                if (en)
                    den_reg[s] <= den_in;
            end

            for (l = 0; l < 3; l++) begin : g_lane
                logic [NUM_W-1:0] rem_in;
                logic [QUO_W-1:0] q_in;

                if (s == 0) begin : g_first
                    assign rem_in = NUM_W'({mag[l], QUO_W'(0)}) + NUM_W'(len);
                    assign q_in   = '0;
                end else begin : g_next
                    assign rem_in = rem_reg[s-1][l];
                    assign q_in   = q_reg[s-1][l];
                end

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        if (rem_in >= dsh)
                        begin
                            rem_reg[s][l] <= rem_in - dsh;
                            q_reg[s][l]   <= q_in | (QUO_W'(1) << K);
                        end
                        else
                        begin
                            rem_reg[s][l] <= rem_in;
                            q_reg[s][l]   <= q_in;
                        end
                    end
                end
            end
        end
    endgenerate

    assign quo[0] = q_reg[DIV_STAGES-1][0];
    assign quo[1] = q_reg[DIV_STAGES-1][1];
    assign quo[2] = q_reg[DIV_STAGES-1][2];

endmodule

FILE: rtl/core/quad_cell_vertex_normals.sv
// Quad cell vertex normals, top level. Pipeline: face, prep, square root and
// divide units; throughput one cell per cycle while the result is not stalled.
// A stalled result freezes the whole pipeline, so input stall follows it.
// Reset (rst_n, async, active low) clears all valid bits; payload is not reset.
// Depends on qcvn_pkg, qcvn_face, qcvn_prep, qcvn_sqrt and qcvn_div.
module quad_cell_vertex_normals #(
    parameter int COORD_WIDTH = qcvn_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [COORD_WIDTH-1:0]        upper_left_x,
    input  logic signed [COORD_WIDTH-1:0]        upper_left_y,
    input  logic signed [COORD_WIDTH-1:0]        upper_left_z,
    input  logic signed [COORD_WIDTH-1:0]        upper_right_x,
    input  logic signed [COORD_WIDTH-1:0]        upper_right_y,
    input  logic signed [COORD_WIDTH-1:0]        upper_right_z,
    input  logic signed [COORD_WIDTH-1:0]        lower_left_x,
    input  logic signed [COORD_WIDTH-1:0]        lower_left_y,
    input  logic signed [COORD_WIDTH-1:0]        lower_left_z,
    input  logic signed [COORD_WIDTH-1:0]        lower_right_x,
    input  logic signed [COORD_WIDTH-1:0]        lower_right_y,
    input  logic signed [COORD_WIDTH-1:0]        lower_right_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [qcvn_pkg::FACE_W-1:0]   first_face_x,
    output logic signed [qcvn_pkg::FACE_W-1:0]   first_face_y,
    output logic signed [qcvn_pkg::FACE_W-1:0]   first_face_z,
    output logic signed [qcvn_pkg::FACE_W-1:0]   second_face_x,
    output logic signed [qcvn_pkg::FACE_W-1:0]   second_face_y,
    output logic signed [qcvn_pkg::FACE_W-1:0]   second_face_z,
    output logic signed [qcvn_pkg::SHARED_W-1:0] shared_x,
    output logic signed [qcvn_pkg::SHARED_W-1:0] shared_y,
    output logic signed [qcvn_pkg::SHARED_W-1:0] shared_z,
    output logic                                 shared_degenerate
);
    import qcvn_pkg::*;

    localparam int FACE_DLY = PREP_STAGES + SQRT_STAGES + DIV_STAGES;
    localparam int INFO_DLY = SQRT_STAGES + DIV_STAGES;

    logic                  en;
    logic                  valid_reg [TOTAL_STAGES];
    logic signed [COORD_WIDTH-1:0] ul [3];
    logic signed [COORD_WIDTH-1:0] ur [3];
    logic signed [COORD_WIDTH-1:0] ll [3];
    logic signed [COORD_WIDTH-1:0] lr [3];
    face_t                 f1 [3];
    face_t                 f2 [3];
    face_t                 f1_dly_reg [FACE_DLY][3];
    face_t                 f2_dly_reg [FACE_DLY][3];
    mag_t                  mag [3];
    mag_t                  mag_dly_reg [SQRT_STAGES][3];
    sign_info_t            info;
    sign_info_t            info_dly_reg [INFO_DLY];
    logic [SQ_W-1:0]       sq_sum;
    logic [ROOT_W-1:0]     root;
    logic [QUO_W-1:0]      quo [3];
    logic signed [SHARED_W-1:0] shared [3];
    sign_info_t            info_out;

    // hold everything while the finished result is stalled
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    assign ul[0] = upper_left_x;
    assign ul[1] = upper_left_y;
    assign ul[2] = upper_left_z;
    assign ur[0] = upper_right_x;
    assign ur[1] = upper_right_y;
    assign ur[2] = upper_right_z;
    assign ll[0] = lower_left_x;
    assign ll[1] = lower_left_y;
    assign ll[2] = lower_left_z;
    assign lr[0] = lower_right_x;
    assign lr[1] = lower_right_y;
    assign lr[2] = lower_right_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOTAL_STAGES; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < TOTAL_STAGES; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    qcvn_face #(
        .CW (COORD_WIDTH)
    ) u_face (
        .clk (clk),
        .en  (en),
        .ul  (ul),
        .ur  (ur),
        .ll  (ll),
        .lr  (lr),
        .f1  (f1),
        .f2  (f2)
    );

    qcvn_prep u_prep (
        .clk    (clk),
        .en     (en),
        .f1     (f1),
        .f2     (f2),
        .mag    (mag),
        .info   (info),
        .sq_sum (sq_sum)
    );

    qcvn_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (sq_sum),
        .root (root)
    );

    qcvn_div u_div (
        .clk (clk),
        .en  (en),
        .mag (mag_dly_reg[SQRT_STAGES-1]),
        .len (root),
        .quo (quo)
    );

    // side delay lines that keep faces, magnitudes and signs aligned
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                f1_dly_reg[0][c]  <= f1[c];
                f2_dly_reg[0][c]  <= f2[c];
                mag_dly_reg[0][c] <= mag[c];
                for (int i = 1; i < FACE_DLY; i++)
                begin
                    f1_dly_reg[i][c] <= f1_dly_reg[i-1][c];
                    f2_dly_reg[i][c] <= f2_dly_reg[i-1][c];
                end
                for (int i = 1; i < SQRT_STAGES; i++)
                    mag_dly_reg[i][c] <= mag_dly_reg[i-1][c];
            end
            info_dly_reg[0] <= info;
            for (int i = 1; i < INFO_DLY; i++)
                info_dly_reg[i] <= info_dly_reg[i-1];
        end
    end

    assign info_out = info_dly_reg[INFO_DLY-1];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic [SHARED_W-1:0] qc;
            qc = (SHARED_W'(quo[c]) > SHARED_W'(SHARED_ONE)) ? SHARED_W'(SHARED_ONE)
                                                             : SHARED_W'(quo[c]);
            if (info_out.degen)
                shared[c] = '0;
            else if (info_out.neg[c])
                shared[c] = -signed'(qc);
            else
                shared[c] = signed'(qc);
        end
    end

    assign out_valid         = valid_reg[TOTAL_STAGES-1];
    assign first_face_x      = f1_dly_reg[FACE_DLY-1][0];
    assign first_face_y      = f1_dly_reg[FACE_DLY-1][1];
    assign first_face_z      = f1_dly_reg[FACE_DLY-1][2];
    assign second_face_x     = f2_dly_reg[FACE_DLY-1][0];
    assign second_face_y     = f2_dly_reg[FACE_DLY-1][1];
    assign second_face_z     = f2_dly_reg[FACE_DLY-1][2];
    assign shared_x          = shared[0];
    assign shared_y          = shared[1];
    assign shared_z          = shared[2];
    assign shared_degenerate = info_out.degen;

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && shared_degenerate |-> shared_x == 0 && shared_y == 0 && shared_z == 0)
        else $error("degenerate result carries a nonzero shared normal");

    a_nondegen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !shared_degenerate |-> shared_x != 0 || shared_y != 0 || shared_z != 0)
        else $error("nonzero sum gave a zero shared normal");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> shared_x <= SHARED_ONE && shared_x >= -SHARED_ONE
                   && shared_y <= SHARED_ONE && shared_y >= -SHARED_ONE
                   && shared_z <= SHARED_ONE && shared_z >= -SHARED_ONE)
        else $error("shared normal component out of unit range");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(shared_x) && $stable(first_face_x))
        else $error("pipeline advanced under output stall");

endmodule
